// ----- sv/ibt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared codes, widths and controller/datapath interface types for the
// interval booking table.
// ----------------------------------------------------------------------------
package ibt_pkg;

    localparam int RES_W = 7;
    localparam int STS_W = 2;

    localparam logic OP_BOOK  = 1'b0;
    localparam logic OP_COUNT = 1'b1;

    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STS_W-1:0] ST_BAD_ORDER = 2'd2;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic insert;
        logic res_load;
    } ibt_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic short_req;
        logic out_free;
    } ibt_stat_t;

endpackage
`default_nettype wire

// ----- sv/ibt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibt_ctrl
// Sequencer: clearing pass, request intake, table scan, insert and result.
// ----------------------------------------------------------------------------
module ibt_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  ibt_pkg::ibt_stat_t stat,
    output ibt_pkg::ibt_cmd_t  cmd
);
    import ibt_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.short_req ? S_RESULT : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT: begin
                cmd.insert = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/ibt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibt_datapath
// Entry memory, scan compare stage, eviction and free-slot tracking, held
// count and result register.
// ----------------------------------------------------------------------------
module ibt_datapath #(
    parameter int TABLE_ENTRIES = 64,
    parameter int COORD_BITS    = 20
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  ibt_pkg::ibt_cmd_t             cmd,
    output ibt_pkg::ibt_stat_t            stat,
    input  wire                           s_opcode,
    input  wire [COORD_BITS-1:0]          s_range_low,
    input  wire [COORD_BITS-1:0]          s_range_high,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [ibt_pkg::RES_W-1:0]     m_result_count,
    output logic [ibt_pkg::STS_W-1:0]     m_status
);
    import ibt_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W = 2 * COORD_BITS + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // entry word: {valid, low, high}
    logic [WORD_W-1:0] mem [TABLE_ENTRIES];
    logic [WORD_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]      addr_reg;
    logic                  rd_active_reg;
    logic                  cmp_vld_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  op_reg;
    logic                  bad_reg;
    logic [COORD_BITS-1:0] lo_reg;
    logic [COORD_BITS-1:0] hi_reg;
    logic [CNT_W-1:0]      removed_reg;
    logic [CNT_W-1:0]      held_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic                  m_valid_reg;
    logic [RES_W-1:0]      m_result_count_reg;
    logic [STS_W-1:0]      m_status_reg;

    logic                  ent_v;
    logic [COORD_BITS-1:0] ent_lo;
    logic [COORD_BITS-1:0] ent_hi;
    logic                  hit;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;

    assign ent_v  = rd_data_reg[WORD_W-1];
    assign ent_lo = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign ent_hi = rd_data_reg[COORD_BITS-1:0];
    assign hit    = cmp_vld_reg && ent_v && (ent_hi >= lo_reg) && (hi_reg >= ent_lo);

    // single write port: clearing pass, eviction or insert
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (cmd.clear) begin
            mem_we = 1'b1;
        end else if (cmd.scan && hit) begin
            mem_we    = 1'b1;
            mem_waddr = cmp_idx_reg;
        end else if (cmd.insert && free_found_reg) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx_reg;
            mem_wdata = {1'b1, lo_reg, hi_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // scan address and compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            rd_active_reg <= 1'b0;
            cmp_vld_reg   <= 1'b0;
        end else if (cmd.clear) begin
            addr_reg <= (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
        end else if (cmd.load) begin
            addr_reg      <= '0;
            rd_active_reg <= 1'b1;
            cmp_vld_reg   <= 1'b0;
        end else if (cmd.scan) begin
            cmp_vld_reg <= rd_active_reg;
            cmp_idx_reg <= addr_reg;
            if (rd_active_reg) begin
                if (addr_reg == LAST_IDX) begin
                    rd_active_reg <= 1'b0;
                end else begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end
        end else begin
            cmp_vld_reg <= 1'b0;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_opcode;
            bad_reg <= (s_range_low > s_range_high);
            lo_reg  <= s_range_low;
            hi_reg  <= s_range_high;
        end
    end

    // eviction count, first free entry, held count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            removed_reg    <= '0;
            held_reg       <= '0;
            free_found_reg <= 1'b0;
        end else if (cmd.load) begin
            removed_reg    <= '0;
            free_found_reg <= 1'b0;
        end else if (cmd.scan && cmp_vld_reg) begin
            if (hit) begin
                removed_reg <= removed_reg + 1'b1;
            end
            if ((!ent_v || hit) && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
        end else if (cmd.insert) begin
            held_reg <= held_reg - removed_reg + CNT_W'(free_found_reg);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            if (op_reg == OP_COUNT) begin
                m_result_count_reg <= RES_W'(held_reg);
                m_status_reg       <= ST_OK;
            end else if (bad_reg) begin
                m_result_count_reg <= '0;
                m_status_reg       <= ST_BAD_ORDER;
            end else begin
                m_result_count_reg <= RES_W'(removed_reg);
                m_status_reg       <= free_found_reg ? ST_OK : ST_FULL;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_count = m_result_count_reg;
    assign m_status       = m_status_reg;

    assign stat.clear_last = (addr_reg == LAST_IDX);
    assign stat.scan_done  = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign stat.short_req  = (s_opcode == OP_COUNT) || (s_range_low > s_range_high);
    assign stat.out_free   = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

// ----- sv/interval_booking_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_booking_table
// Holds up to TABLE_ENTRIES disjoint closed intervals. A booking request
// evicts every held interval that overlaps the new one, stores the new one in
// the lowest free entry and returns the eviction count; a count request
// returns the number held. After reset the entry memory is cleared in a pass
// over every entry before the first request is taken. A booking is compared
// with each entry once through the single memory read port, then inserts
// and loads its result, and the next request is taken after that; a count
// request or a booking with low above high skips the scan and insert and
// goes straight to the result register. The result sits in an output
// register, so a new request is taken while it waits.
// ----------------------------------------------------------------------------
module interval_booking_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int COORD_BITS    = 20
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_opcode,
    input  wire [COORD_BITS-1:0]          s_range_low,
    input  wire [COORD_BITS-1:0]          s_range_high,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [ibt_pkg::RES_W-1:0]     m_result_count,
    output logic [ibt_pkg::STS_W-1:0]     m_status
);
    import ibt_pkg::*;

    ibt_cmd_t  cmd;
    ibt_stat_t stat;

    ibt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ibt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COORD_BITS    (COORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_range_low    (s_range_low),
        .s_range_high   (s_range_high),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_count (m_result_count),
        .m_status       (m_status)
    );

endmodule
`default_nettype wire

// ----- dv/interval_booking_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_booking_table_test
// Self-checking bench for the interval booking table. A queue of booking and
// count requests (a directed opening, then random sequences that fill,
// wipe, churn and send noise to the table) feeds a valid/ready driver with
// random idle gaps. A scoreboard model of the table predicts each result
// as the request is taken, and a monitor with random back-pressure checks
// every result against the oldest prediction.
// ----------------------------------------------------------------------------
module interval_booking_table_test;

    import ibt_pkg::*;

    localparam int TABLE_ENTRIES = 64;
    localparam int COORD_BITS    = 20;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 150;

    typedef struct {
        logic                  op;
        logic [COORD_BITS-1:0] lo;
        logic [COORD_BITS-1:0] hi;
        bit                    hold;
    } request_t;

    typedef struct {
        logic [RES_W-1:0] result_count;
        logic [STS_W-1:0] status;
    } booking_result_t;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_opcode       = OP_BOOK;
    logic [COORD_BITS-1:0] s_range_low    = '0;
    logic [COORD_BITS-1:0] s_range_high   = '0;
    logic                  m_ready        = 1'b0;
    wire                   s_ready;
    wire                   m_valid;
    wire  [RES_W-1:0]      m_result_count;
    wire  [STS_W-1:0]      m_status;

    request_t        pending_requests[$];
    booking_result_t expected_results[$];
    booking_result_t head_result;
    request_t        next_request;

    // scoreboard copy of the table
    bit                    held_valid[TABLE_ENTRIES];
    logic [COORD_BITS-1:0] held_low[TABLE_ENTRIES];
    logic [COORD_BITS-1:0] held_high[TABLE_ENTRIES];
    int                    held_total = 0;

    bit req_taken   = 1'b0;
    bit resp_taken  = 1'b0;
    bit gap_ready   = 1'b0;
    bit send_burst  = 1'b0;
    bit recv_burst  = 1'b0;
    int gap_left    = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int mismatch_count = 0;

    interval_booking_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .COORD_BITS   (COORD_BITS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_count(m_result_count),
        .m_status      (m_status)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int idle_draw(bit burst);
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic booking_result_t predict_result(logic op, logic [COORD_BITS-1:0] lo,
                                                       logic [COORD_BITS-1:0] hi);
        booking_result_t r;
        int evicted;
        int free_slot;
        r.result_count = '0;
        r.status       = ST_OK;
        evicted        = 0;
        free_slot      = -1;
        if (op == OP_COUNT) begin
            r.result_count = RES_W'(held_total);
        end else if (lo > hi) begin
            r.status = ST_BAD_ORDER;
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (held_valid[i] && held_high[i] >= lo && hi >= held_low[i]) begin
                    held_valid[i] = 1'b0;
                    evicted++;
                    if (held_total > 0) held_total--;
                end
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!held_valid[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
                r.status = ST_FULL;
            end else begin
                held_valid[free_slot] = 1'b1;
                held_low[free_slot]   = lo;
                held_high[free_slot]  = hi;
                held_total++;
            end
            r.result_count = RES_W'(evicted);
        end
        return r;
    endfunction

    task automatic queue_request(logic op, int lo, int hi, bit hold);
        request_t r;
        r.op   = op;
        r.lo   = COORD_BITS'(lo);
        r.hi   = COORD_BITS'(hi);
        r.hold = hold;
        pending_requests.push_back(r);
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!(s_valid && !req_taken)) begin
                if (!gap_ready) begin
                    gap_left  = idle_draw(send_burst);
                    gap_ready = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0 &&
                             (!pending_requests[0].hold || expected_results.size() == 0)) begin
                    next_request = pending_requests.pop_front();
                    s_opcode     <= next_request.op;
                    s_range_low  <= next_request.lo;
                    s_range_high <= next_request.hi;
                    s_valid      <= 1'b1;
                    gap_ready    = 1'b0;
                    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (resp_taken) begin
                stall_left = idle_draw(recv_burst);
                if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                if (m_valid) stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            req_taken  <= s_valid && s_ready;
            resp_taken <= m_valid && m_ready;
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_opcode, s_range_low, s_range_high));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: result_count %0d status %0d",
                           m_result_count, m_status);
                    mismatch_count++;
                end else begin
                    head_result = expected_results.pop_front();
                    if (m_result_count !== head_result.result_count) begin
                        $error("result_count expected %0d actual %0d",
                               head_result.result_count, m_result_count);
                        mismatch_count++;
                    end
                    if (m_status !== head_result.status) begin
                        $error("status expected %0d actual %0d",
                               head_result.status, m_status);
                        mismatch_count++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    initial begin
        int generated;
        int kind;
        int pos;
        int lo;
        int hi;
        int n;
        bit hold;

        for (int i = 0; i < TABLE_ENTRIES; i++) held_valid[i] = 1'b0;

        // directed opening
        queue_request(OP_COUNT, 0, 0, 1'b0);
        queue_request(OP_BOOK, 0, 0, 1'b0);
        queue_request(OP_BOOK, COORD_MAX, COORD_MAX, 1'b0);
        queue_request(OP_COUNT, COORD_MAX, COORD_MAX, 1'b0);
        queue_request(OP_BOOK, 0, COORD_MAX, 1'b0);
        queue_request(OP_COUNT, 12345, 3, 1'b0);
        queue_request(OP_BOOK, COORD_MAX, 0, 1'b0);
        queue_request(OP_BOOK, 1, 0, 1'b0);
        queue_request(OP_BOOK, 10, 20, 1'b0);
        queue_request(OP_BOOK, 20, 30, 1'b0);
        queue_request(OP_BOOK, 31, 40, 1'b0);
        queue_request(OP_BOOK, 5, 9, 1'b0);
        queue_request(OP_BOOK, 41, 41, 1'b0);
        queue_request(OP_COUNT, 0, COORD_MAX, 1'b0);
        queue_request(OP_BOOK, 9, 31, 1'b0);
        queue_request(OP_BOOK, 42, COORD_MAX - 1, 1'b0);
        queue_request(OP_COUNT, 0, 0, 1'b0);
        queue_request(OP_BOOK, 0, COORD_MAX, 1'b0);
        queue_request(OP_COUNT, 0, 0, 1'b0);

        // random sequences
        generated = 0;
        hold      = 1'b1;
        while (generated < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 8);
            if (kind < 2) begin
                // fill: ascending narrow disjoint bookings, can overflow the table
                n   = $urandom_range(64, 72);
                pos = $urandom_range(0, 900000);
                for (int i = 0; i < n; i++) begin
                    lo  = pos;
                    hi  = lo + $urandom_range(0, 15);
                    pos = hi + 1 + $urandom_range(0, 1000);
                    queue_request(OP_BOOK, lo, hi, hold && i == 0);
                    if ($urandom_range(0, 9) == 0) begin
                        queue_request(OP_COUNT, $urandom, $urandom, 1'b0);
                        generated++;
                    end
                end
                generated += n;
            end else if (kind == 2) begin
                // wipe: wide booking evicting most of the table
                if ($urandom_range(0, 1)) begin
                    lo = 0;
                    hi = COORD_MAX;
                end else begin
                    lo = $urandom_range(0, 1000);
                    hi = $urandom_range(COORD_MAX - 1000, COORD_MAX);
                end
                queue_request(OP_BOOK, lo, hi, hold);
                queue_request(OP_COUNT, $urandom, $urandom, 1'b0);
                generated += 2;
            end else if (kind < 8) begin
                // churn: mostly well-formed bookings of mixed width
                for (int i = 0; i < 20; i++) begin
                    lo = $urandom_range(0, COORD_MAX);
                    if ($urandom_range(0, 3) == 0) hi = lo + $urandom_range(0, 60000);
                    else hi = lo + $urandom_range(0, 200);
                    if (hi > COORD_MAX) hi = COORD_MAX;
                    if ($urandom_range(0, 9) == 0) begin
                        n  = lo;
                        lo = $urandom_range(1, COORD_MAX);
                        hi = $urandom_range(0, lo - 1);
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        queue_request(OP_COUNT, $urandom, $urandom, hold && i == 0);
                    end else begin
                        queue_request(OP_BOOK, lo, hi, hold && i == 0);
                    end
                end
                generated += 20;
            end else begin
                // noise: unconstrained fields
                for (int i = 0; i < 10; i++) begin
                    queue_request(1'($urandom_range(0, 1)), $urandom, $urandom,
                                  hold && i == 0);
                end
                generated += 10;
            end
            hold = ($urandom_range(0, 7) == 0);
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() > 0 || s_valid) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- interval_booking_table.f -----
sv/ibt_pkg.sv
sv/ibt_ctrl.sv
sv/ibt_datapath.sv
sv/interval_booking_table.sv
dv/interval_booking_table_test.sv
